>>> rtl/ddm_pkg.sv
// Shared constants and payload types for the differential drive mixer.
`default_nettype none
package ddm_pkg;

   // Stick format: signed Q1.(IN_W-1)
   localparam int IN_W      = 16;
   localparam int FRAC      = IN_W - 1;
   localparam int K_W       = IN_W + 1;          // |x|+|y|
   localparam int SQ_W      = 2 * IN_W - 1;      // |y|^2 and |y|*arc
   localparam int CMP_W     = K_W + IN_W - 1;    // divisor shifted by the top quotient bit
   localparam int N_W       = 2 * IN_W + 1;      // blended value, units 2^-2*FRAC
   localparam int PWM_MAX   = 1023;
   localparam int PWM_MAX_W = $clog2(PWM_MAX + 1);
   localparam int PROD_W    = N_W + PWM_MAX_W;
   localparam int SPEED_W   = 10;

   typedef struct packed {
      logic signed [IN_W-1:0] stick_x;
      logic signed [IN_W-1:0] stick_y;
   } ddm_req_type;

   typedef struct packed {
      logic [SPEED_W-1:0] left_speed;
      logic               left_backward;
      logic [SPEED_W-1:0] right_speed;
      logic               right_backward;
   } ddm_rsp_type;

   // Data that rides alongside the divider
   typedef struct packed {
      logic [IN_W-1:0]        ay;
      logic signed [IN_W-1:0] x;
      logic                   x_pos;
      logic                   y_pos;
      logic                   y_neg;
   } ddm_side_type;

endpackage
`default_nettype wire

>>> rtl/differential_drive_mixer.sv
// Top level of the differential drive mixer pipeline.
`default_nettype none
// Arcade mixing of a joystick item (turn x, throttle y) into left and right
// PWM duties with direction bits. One item is taken every cycle while busy is
// low; busy is high during reset and in the cycle after it. Each item's result
// appears on rsp_data with rsp_strobe high for a single cycle, after passing
// the input and magnitude registers, the |y|^2 multiply, one stage per quotient
// bit of the 16-stage divider for |y|^2/(|x|+|y|), mix multiply, sum, duty
// multiply and the output register. The receiver has no way to stall, so it
// must take every strobed item. The swap bit (reset 1) exchanges the channels.
module differential_drive_mixer (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire ddm_pkg::ddm_req_type  req_data,
   output logic                       rsp_strobe,
   output ddm_pkg::ddm_rsp_type       rsp_data,
   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_wr_data
);
   import ddm_pkg::*;

   localparam logic [IN_W-1:0] S_ONE = IN_W'(1) << FRAC;

   logic busy_ff;
   logic swap_ff;

   // s0: accepted item
   logic                   vld0_ff;
   logic signed [IN_W-1:0] x0_ff, y0_ff;

   // s1: magnitudes
   logic                   vld1_ff;
   logic [IN_W-1:0]        ay1_ff, ay1_in, ax1;
   logic [K_W-1:0]         k1_ff, k1_in;
   ddm_side_type           side1_ff, side1_in;

   // s2: |y|^2
   logic                   vld2_ff;
   logic [SQ_W-1:0]        sq2_ff, sq2_in;
   logic [K_W-1:0]         k2_ff;
   ddm_side_type           side2_ff;

   // divider out
   logic                   dv_vld;
   logic [IN_W-1:0]        dv_quo;
   ddm_side_type           dv_side;

   // s3: products
   logic                   vld3_ff;
   logic [SQ_W-1:0]        pa_l_ff, pa_l_in, pa_r_ff, pa_r_in;
   logic signed [N_W-1:0]  tank_ff, tank_in;
   logic                   ypos3_ff, yneg3_ff;
   logic [IN_W-1:0]        arc_l, arc_r, s_minus;

   // s4: blended values
   logic                   vld4_ff;
   logic signed [N_W-1:0]  nl_ff, nl_in, nr_ff, nr_in;
   logic signed [N_W-1:0]  arc_term_l, arc_term_r;

   always_comb begin
      ax1    = x0_ff[IN_W-1] ? IN_W'(~x0_ff + 1'b1) : IN_W'(x0_ff);
      ay1_in = y0_ff[IN_W-1] ? IN_W'(~y0_ff + 1'b1) : IN_W'(y0_ff);
      k1_in  = K_W'(ax1) + K_W'(ay1_in);
      side1_in.ay    = ay1_in;
      side1_in.x     = x0_ff;
      side1_in.x_pos = !x0_ff[IN_W-1] && (x0_ff != '0);
      side1_in.y_pos = !y0_ff[IN_W-1] && (y0_ff != '0);
      side1_in.y_neg = y0_ff[IN_W-1];
   end

   assign sq2_in = SQ_W'(ay1_ff) * SQ_W'(ay1_ff);

   ddm_divider u_div (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (vld2_ff),
      .in_dividend (sq2_ff),
      .in_divisor  (k2_ff),
      .in_side     (side2_ff),
      .out_valid   (dv_vld),
      .out_quo     (dv_quo),
      .out_side    (dv_side)
   );

   // outer wheel runs at |y|, inner at the quotient
   always_comb begin
      arc_l   = dv_side.x_pos ? dv_side.ay : dv_quo;
      arc_r   = dv_side.x_pos ? dv_quo : dv_side.ay;
      s_minus = S_ONE - dv_side.ay;
      pa_l_in = SQ_W'(dv_side.ay) * SQ_W'(arc_l);
      pa_r_in = SQ_W'(dv_side.ay) * SQ_W'(arc_r);
      tank_in = N_W'($signed({1'b0, s_minus})) * N_W'(dv_side.x);
   end

   always_comb begin
      arc_term_l = '0;
      arc_term_r = '0;
      if (ypos3_ff) begin
         arc_term_l = $signed({2'b00, pa_l_ff});
         arc_term_r = $signed({2'b00, pa_r_ff});
      end else if (yneg3_ff) begin
         arc_term_l = -$signed({2'b00, pa_l_ff});
         arc_term_r = -$signed({2'b00, pa_r_ff});
      end
      nl_in = arc_term_l + tank_ff;
      nr_in = arc_term_r - tank_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
         swap_ff <= 1'b1;
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_wr_en) swap_ff <= csr_wr_data;
         vld0_ff <= start && !busy_ff;
         vld1_ff <= vld0_ff;
         vld2_ff <= vld1_ff;
         vld3_ff <= dv_vld;
         vld4_ff <= vld3_ff;
      end
      x0_ff    <= req_data.stick_x;
      y0_ff    <= req_data.stick_y;
      ay1_ff   <= ay1_in;
      k1_ff    <= k1_in;
      side1_ff <= side1_in;
      sq2_ff   <= sq2_in;
      k2_ff    <= k1_ff;
      side2_ff <= side1_ff;
      pa_l_ff  <= pa_l_in;
      pa_r_ff  <= pa_r_in;
      tank_ff  <= tank_in;
      ypos3_ff <= dv_side.y_pos;
      yneg3_ff <= dv_side.y_neg;
      nl_ff    <= nl_in;
      nr_ff    <= nr_in;
   end

   ddm_pwm u_pwm (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (vld4_ff),
      .in_n_l    (nl_ff),
      .in_n_r    (nr_ff),
      .swap      (swap_ff),
      .out_valid (rsp_strobe),
      .out_rsp   (rsp_data)
   );

   assign busy = busy_ff;

endmodule
`default_nettype wire

>>> rtl/ddm_divider.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
`default_nettype none
module ddm_divider (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   input  wire logic [ddm_pkg::SQ_W-1:0]  in_dividend,
   input  wire logic [ddm_pkg::K_W-1:0]   in_divisor,
   input  wire ddm_pkg::ddm_side_type     in_side,
   output logic                           out_valid,
   output logic [ddm_pkg::IN_W-1:0]       out_quo,
   output ddm_pkg::ddm_side_type          out_side
);
   import ddm_pkg::*;

   // stage views: index 0 is the input, index i+1 the register after step i
   logic                 stg_vld  [0:IN_W];
   logic [SQ_W-1:0]      stg_rem  [0:IN_W];
   logic [K_W-1:0]       stg_dsr  [0:IN_W];
   logic [IN_W-1:0]      stg_quo  [0:IN_W];
   ddm_side_type         stg_side [0:IN_W];

   logic                 vld_ff   [0:IN_W-1];
   logic [SQ_W-1:0]      rem_ff   [0:IN_W-1];
   logic [SQ_W-1:0]      rem_in   [0:IN_W-1];
   logic [K_W-1:0]       dsr_ff   [0:IN_W-1];
   logic [IN_W-1:0]      quo_ff   [0:IN_W-1];
   logic [IN_W-1:0]      quo_in   [0:IN_W-1];
   ddm_side_type         side_ff  [0:IN_W-1];

   assign stg_vld[0]  = in_valid;
   assign stg_rem[0]  = in_dividend;
   assign stg_dsr[0]  = in_divisor;
   assign stg_quo[0]  = '0;
   assign stg_side[0] = in_side;

   for (genvar i = 0; i < IN_W; i++) begin : g_step
      localparam int BIT = IN_W - 1 - i;
      logic [CMP_W-1:0] trial;
      logic [CMP_W-1:0] diff;

      always_comb begin
         trial     = CMP_W'(stg_dsr[i]) << BIT;
         diff      = CMP_W'(stg_rem[i]) - trial;
         rem_in[i] = stg_rem[i];
         quo_in[i] = stg_quo[i];
         if (CMP_W'(stg_rem[i]) >= trial) begin
            rem_in[i]      = diff[SQ_W-1:0];
            quo_in[i][BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else begin
            vld_ff[i] <= stg_vld[i];
         end
         rem_ff[i]  <= rem_in[i];
         dsr_ff[i]  <= stg_dsr[i];
         quo_ff[i]  <= quo_in[i];
         side_ff[i] <= stg_side[i];
      end

      assign stg_vld[i+1]  = vld_ff[i];
      assign stg_rem[i+1]  = rem_ff[i];
      assign stg_dsr[i+1]  = dsr_ff[i];
      assign stg_quo[i+1]  = quo_ff[i];
      assign stg_side[i+1] = side_ff[i];
   end

   assign out_valid = stg_vld[IN_W];
   assign out_quo   = stg_quo[IN_W];
   assign out_side  = stg_side[IN_W];

endmodule
`default_nettype wire

>>> rtl/ddm_pwm.sv
// Blended value to PWM duty and direction, two stages, with side swap.
`default_nettype none
module ddm_pwm (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   input  wire logic signed [ddm_pkg::N_W-1:0] in_n_l,
   input  wire logic signed [ddm_pkg::N_W-1:0] in_n_r,
   input  wire logic                       swap,
   output logic                            out_valid,
   output ddm_pkg::ddm_rsp_type            out_rsp
);
   import ddm_pkg::*;

   logic              vld_a_ff;
   logic [PROD_W-1:0] prod_l_ff, prod_l_in;
   logic [PROD_W-1:0] prod_r_ff, prod_r_in;
   logic              neg_l_ff, neg_r_ff;
   logic [N_W-1:0]    mag_l, mag_r;

   logic              vld_b_ff;
   ddm_rsp_type       rsp_ff, rsp_in;
   logic [PROD_W-1:0] duty_l, duty_r;
   logic [SPEED_W-1:0] spd_l, spd_r;

   always_comb begin
      mag_l     = in_n_l[N_W-1] ? N_W'(-in_n_l) : N_W'(in_n_l);
      mag_r     = in_n_r[N_W-1] ? N_W'(-in_n_r) : N_W'(in_n_r);
      prod_l_in = PROD_W'(mag_l) * PROD_W'(PWM_MAX);
      prod_r_in = PROD_W'(mag_r) * PROD_W'(PWM_MAX);
   end

   always_comb begin
      duty_l = prod_l_ff >> (2 * FRAC);
      duty_r = prod_r_ff >> (2 * FRAC);
      if (duty_l > PROD_W'(PWM_MAX)) duty_l = PROD_W'(PWM_MAX);
      if (duty_r > PROD_W'(PWM_MAX)) duty_r = PROD_W'(PWM_MAX);
      spd_l = duty_l[SPEED_W-1:0];
      spd_r = duty_r[SPEED_W-1:0];
      if (swap) begin
         rsp_in.left_speed     = spd_r;
         rsp_in.left_backward  = neg_r_ff;
         rsp_in.right_speed    = spd_l;
         rsp_in.right_backward = neg_l_ff;
      end else begin
         rsp_in.left_speed     = spd_l;
         rsp_in.left_backward  = neg_l_ff;
         rsp_in.right_speed    = spd_r;
         rsp_in.right_backward = neg_r_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
      end else begin
         vld_a_ff <= in_valid;
         vld_b_ff <= vld_a_ff;
      end
      prod_l_ff <= prod_l_in;
      prod_r_ff <= prod_r_in;
      neg_l_ff  <= in_n_l[N_W-1];
      neg_r_ff  <= in_n_r[N_W-1];
      rsp_ff    <= rsp_in;
   end

   assign out_valid = vld_b_ff;
   assign out_rsp   = rsp_ff;

endmodule
`default_nettype wire

>>> test/differential_drive_mixer_tb.sv
// Self-checking testbench for the differential drive mixer: queued stick items, predicted duties.
module differential_drive_mixer_tb;
   import ddm_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   ddm_req_type req_data = '0;
   logic        rsp_strobe;
   ddm_rsp_type rsp_data;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   ddm_req_type pending_q[$];
   ddm_rsp_type drive_q[$];
   logic        swap_model = 1'b1;
   logic        item_taken = 1'b0;
   logic        gaps_on = 1'b1;
   int          gap_left = 0;
   int          mismatches = 0;

   differential_drive_mixer uut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Blended value in units 2^-2*FRAC to duty and direction.
   function automatic void duty_of(input longint n, output logic [SPEED_W-1:0] spd,
                                   output logic bwd);
      longint mag;
      longint p;
      mag = (n < 0) ? -n : n;
      p   = (mag * PWM_MAX) >>> (2 * FRAC);
      if (p > PWM_MAX) p = PWM_MAX;
      spd = p[SPEED_W-1:0];
      bwd = (n < 0);
   endfunction

   function automatic ddm_rsp_type mix_drive(input ddm_req_type cmd, input logic swap);
      longint x, y, full, ax, ay, k, q, sy, arc_l, arc_r, n_l, n_r;
      logic [SPEED_W-1:0] sl, sr;
      logic bl, br;
      ddm_rsp_type r;
      x     = cmd.stick_x;
      y     = cmd.stick_y;
      full  = longint'(1) << FRAC;
      ax    = (x < 0) ? -x : x;
      ay    = (y < 0) ? -y : y;
      k     = ax + ay;
      q     = (k == 0) ? 0 : (ay * ay) / k;
      sy    = (y > 0) ? 1 : ((y < 0) ? -1 : 0);
      // outer wheel runs at |y|, inner at the quotient
      arc_l = (x > 0) ? ay : q;
      arc_r = (x > 0) ? q : ay;
      n_l   = sy * ay * arc_l + (full - ay) * x;
      n_r   = sy * ay * arc_r - (full - ay) * x;
      duty_of(n_l, sl, bl);
      duty_of(n_r, sr, br);
      if (swap) begin
         r.left_speed = sr; r.left_backward = br;
         r.right_speed = sl; r.right_backward = bl;
      end else begin
         r.left_speed = sl; r.left_backward = bl;
         r.right_speed = sr; r.right_backward = br;
      end
      return r;
   endfunction

   function automatic logic signed [IN_W-1:0] rand_stick();
      logic signed [IN_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = $urandom_range(0, 1) ? {1'b1, {FRAC{1'b0}}} : {1'b0, {FRAC{1'b1}}};
         1, 2: begin
            v = IN_W'($urandom_range(0, 64));
            if ($urandom_range(0, 1)) v = -v;
         end
         default: v = IN_W'($urandom);
      endcase
      return v;
   endfunction

   task automatic queue_random(input int count);
      ddm_req_type item;
      for (int i = 0; i < count; i++) begin
         item.stick_x = rand_stick();
         item.stick_y = rand_stick();
         pending_q.push_back(item);
      end
   endtask

   // Sampled at the rising edge: all items queued, presented and answered.
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_q.size() != 0 || start || drive_q.size() != 0);
   endtask

   task automatic write_swap(input logic value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // Driver: present items from the queue, hold each until taken.
   always @(negedge clock) begin : drive_items
      logic        next_start;
      ddm_req_type next_data;
      next_start = start;
      next_data  = req_data;
      if (start && item_taken) next_start = 1'b0;
      if (!next_start && !reset) begin
         if (gap_left > 0) begin
            gap_left = gap_left - 1;
         end else if (pending_q.size() != 0) begin
            next_data  = pending_q.pop_front();
            next_start = 1'b1;
            if (gaps_on && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 18);
         end
      end
      start    <= next_start;
      req_data <= next_data;
   end

   // Monitor: predict on acceptance, compare each strobed result.
   always @(posedge clock) begin : check_drive
      ddm_rsp_type want;
      item_taken <= !reset && start && !busy;
      if (reset) swap_model <= 1'b1;
      else if (csr_wr_en) swap_model <= csr_wr_data;
      if (!reset && rsp_strobe) begin
         if (drive_q.size() == 0) begin
            $error("result with no item outstanding");
            mismatches++;
         end else begin
            want = drive_q.pop_front();
            if (rsp_data.left_speed !== want.left_speed) begin
               $error("left_speed: expected %0d, got %0d", want.left_speed,
                      rsp_data.left_speed);
               mismatches++;
            end
            if (rsp_data.left_backward !== want.left_backward) begin
               $error("left_backward: expected %0b, got %0b", want.left_backward,
                      rsp_data.left_backward);
               mismatches++;
            end
            if (rsp_data.right_speed !== want.right_speed) begin
               $error("right_speed: expected %0d, got %0d", want.right_speed,
                      rsp_data.right_speed);
               mismatches++;
            end
            if (rsp_data.right_backward !== want.right_backward) begin
               $error("right_backward: expected %0b, got %0b", want.right_backward,
                      rsp_data.right_backward);
               mismatches++;
            end
         end
      end
      if (!reset && start && !busy) drive_q.push_back(mix_drive(req_data, swap_model));
   end

   initial begin
      static int corner_x[22] = '{0, 32767, -32768, 0, 0, -32768, 32767, -32768, 32767, 1,
                                  -1, 0, 0, -1, 1, 100, -32768, 12345, -20000, 16384,
                                  -16384, 5};
      static int corner_y[22] = '{0, 0, 0, 32767, -32768, -32768, 32767, 32767, -32768, 0,
                                  0, 1, -1, -1, -1, -3, 1, -6789, 15000, 16384, 16384,
                                  -32768};
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // corners, zero stick, tank only, tiny negatives; swap at its reset value
      for (int i = 0; i < 22; i++)
         pending_q.push_back('{stick_x: IN_W'(corner_x[i]), stick_y: IN_W'(corner_y[i])});
      wait_drained();

      write_swap(1'b0);
      queue_random(500);
      wait_drained();

      write_swap(1'b1);
      queue_random(500);
      wait_drained();

      // back-to-back items to the end
      write_swap(1'b0);
      gaps_on = 1'b0;
      queue_random(700);
      wait_drained();

      repeat (30) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> differential_drive_mixer.f
rtl/ddm_pkg.sv
rtl/ddm_divider.sv
rtl/ddm_pwm.sv
rtl/differential_drive_mixer.sv
test/differential_drive_mixer_tb.sv
